### hw/rtl/min_window_sum_locator_core_defines.svh
// Assertion macros for the minimum window sum locator.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef MIN_WINDOW_SUM_LOCATOR_CORE_DEFINES_SVH
`define MIN_WINDOW_SUM_LOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH
`define MWSL_ASSERT_CLK(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("mwsl: assertion failed");
`define MWSL_ASSERT(label, prop) \
  `MWSL_ASSERT_CLK(label, clk, rst, prop)
`else
`define MWSL_ASSERT_CLK(label, clk_sig, rst_sig, prop)
`define MWSL_ASSERT(label, prop)
`endif

`endif

### hw/rtl/mwsl_pkg.sv
// Shared types and constants for the minimum window sum locator.
// No dependencies; mwsl_row_store, min_window_sum_locator_core and the testbench import this package.
`default_nettype none

package mwsl_pkg;

  // Fixed field widths of the channels and registers.
  localparam int CELL_W      = 16;
  localparam int SUM_OUT_W   = 20;
  localparam int POS_OUT_W   = 10;
  localparam int CFG_W       = 11;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // Window edge length and default sizing.
  localparam int WIN             = 3;
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_VALUE_BITS  = 16;

  localparam logic [CFG_W-1:0] GRID_DIM_RESET = CFG_W'(3);

  // Register index, taken from address bit 2.
  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
  } cell_t;

  typedef struct packed {
    logic [SUM_OUT_W-1:0] lowest_sum;
    logic [POS_OUT_W-1:0] best_column;
    logic [POS_OUT_W-1:0] best_row;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/mwsl_stream_if.sv
// Valid/ready stream channel used for cells and results.
// The payload type is supplied by the instantiating scope, normally from mwsl_pkg.
`default_nettype none

interface mwsl_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

### hw/rtl/mwsl_row_store.sv
// Two-row history memory: each entry holds the cells one and two rows above.
// Depends on mwsl_pkg; used by min_window_sum_locator_core.
`default_nettype none

module mwsl_row_store
  import mwsl_pkg::*;
#(
  parameter int DEPTH      = DEF_MAX_COLUMNS,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  localparam int ADDR_W    = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rd_en,
  input  wire logic [ADDR_W-1:0]     rd_addr,
  output logic      [VALUE_BITS-1:0] older,
  output logic      [VALUE_BITS-1:0] newer,
  input  wire logic                  wr_en,
  input  wire logic [ADDR_W-1:0]     wr_addr,
  input  wire logic [VALUE_BITS-1:0] wr_value
);

  logic [2*VALUE_BITS-1:0] mem [DEPTH];
  logic [2*VALUE_BITS-1:0] rd_q;

  // The write of an entry ages it by one row: the previous newer cell moves
  // to the older half and the incoming cell becomes the newer half. The read
  // data for that same column is still held in rd_q when the write happens.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= {rd_q[VALUE_BITS-1:0], wr_value};
    end
  end

  assign older = rd_q[2*VALUE_BITS-1:VALUE_BITS];
  assign newer = rd_q[VALUE_BITS-1:0];

endmodule

`default_nettype wire

### hw/rtl/min_window_sum_locator_core.sv
// Minimum 3x3 window sum locator: top level, with mwsl_row_store and mwsl_stream_if.
// Depends on mwsl_pkg and min_window_sum_locator_core_defines.svh.
// Throughput: one cell per clock; the only pause is on the last cell of a grid
// while the previous grid's result still sits untaken in the output register.
// A grid's result is registered: its last cell passes the s1 stage register, then the output register.
// Reset (synchronous, active high) clears positions, best tracking and output valid.
`default_nettype none

`include "min_window_sum_locator_core_defines.svh"

module min_window_sum_locator_core
  import mwsl_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  mwsl_stream_if.sink                cells,
  mwsl_stream_if.source              results
);

  // Position counters are sized by the largest grid. The dimension compare
  // width covers both the register width and a counter plus one.
  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int DIM_W = (CFG_W > POS_W + 1) ? CFG_W : POS_W + 1;
  // A column sum adds three cells and a window sum adds nine.
  localparam int CS_W  = VALUE_BITS + 2;
  localparam int WS_W  = VALUE_BITS + 4;

  localparam logic [DIM_W-1:0] WIN_DIM     = DIM_W'(WIN);
  localparam logic [DIM_W-1:0] MAX_COL_DIM = DIM_W'(MAX_COLUMNS);
  localparam logic [DIM_W-1:0] MAX_ROW_DIM = DIM_W'(MAX_ROWS);

  // ---------------------------------------------------------------------
  // Configuration registers. The register index is address bit 2; pready
  // is tied high, so a write lands on the access phase.
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_DIM_RESET;
      grid_height <= GRID_DIM_RESET;
    end else if (cfg_write) begin
      case (reg_idx_t'(paddr[2]))
        REG_GRID_WIDTH:  grid_width  <= pwdata[CFG_W-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_GRID_WIDTH:  prdata = APB_DATA_W'(grid_width);
      REG_GRID_HEIGHT: prdata = APB_DATA_W'(grid_height);
      default:         prdata = '0;
    endcase
  end

  // Register values outside the supported range are saturated when used.
  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;

  always_comb begin
    if (DIM_W'(grid_width) < WIN_DIM) begin
      width_eff = WIN_DIM;
    end else if (DIM_W'(grid_width) > MAX_COL_DIM) begin
      width_eff = MAX_COL_DIM;
    end else begin
      width_eff = DIM_W'(grid_width);
    end
    if (DIM_W'(grid_height) < WIN_DIM) begin
      height_eff = WIN_DIM;
    end else if (DIM_W'(grid_height) > MAX_ROW_DIM) begin
      height_eff = MAX_ROW_DIM;
    end else begin
      height_eff = DIM_W'(grid_height);
    end
  end

  // ---------------------------------------------------------------------
  // Input stage: raster position of the next cell. The position alone tells
  // whether this cell closes a row or the grid, so the input can be held
  // back only for the last cell, and only while the output register is
  // still occupied by an untaken result. A grid holds at least nine cells,
  // so no other result can be in flight at that point.
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic             col_end;
  logic             row_end;
  logic             last_now;
  logic             cell_xfer;
  logic             res_valid;

  assign col_end   = (DIM_W'(col_pos) + DIM_W'(1)) >= width_eff;
  assign row_end   = (DIM_W'(row_pos) + DIM_W'(1)) >= height_eff;
  assign last_now  = col_end && row_end;
  assign cells.ready = !last_now || !res_valid || results.ready;
  assign cell_xfer = cells.valid && cells.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (cell_xfer) begin
      if (col_end) begin
        col_pos <= '0;
        row_pos <= row_end ? '0 : row_pos + ROW_W'(1);
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

  // Stage register between the transfer and the summing logic. The row
  // store read for the same column is registered alongside it.
  logic                  s1_valid;
  logic                  s1_last;
  logic                  s1_window;
  logic [VALUE_BITS-1:0] s1_value;
  logic [COL_W-1:0]      s1_col;
  logic [ROW_W-1:0]      s1_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cell_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_xfer) begin
      s1_last   <= last_now;
      s1_window <= (col_pos >= COL_W'(WIN - 1)) && (row_pos >= ROW_W'(WIN - 1));
      s1_value  <= VALUE_BITS'(cells.data.cell_value);
      s1_col    <= col_pos;
      s1_row    <= row_pos;
    end
  end

  logic [VALUE_BITS-1:0] older_cell;
  logic [VALUE_BITS-1:0] newer_cell;

  mwsl_row_store #(
    .DEPTH      (MAX_COLUMNS),
    .VALUE_BITS (VALUE_BITS)
  ) u_row_store (
    .clk      (clk),
    .rd_en    (cell_xfer),
    .rd_addr  (col_pos),
    .older    (older_cell),
    .newer    (newer_cell),
    .wr_en    (s1_valid),
    .wr_addr  (s1_col),
    .wr_value (s1_value)
  );

  // ---------------------------------------------------------------------
  // Summing stage: the column sum of the current cell plus the two previous
  // column sums gives the window whose bottom-right cell just arrived. The
  // strict compare keeps the first window in raster order on a tie.
  // ---------------------------------------------------------------------
  logic [CS_W-1:0]  cs_prev2;
  logic [CS_W-1:0]  cs_prev1;
  logic [CS_W-1:0]  col_sum;
  logic [WS_W-1:0]  win_sum;
  logic             found;
  logic [WS_W-1:0]  best_sum;
  logic [COL_W-1:0] best_col;
  logic [ROW_W-1:0] best_row;
  logic             take;
  logic [WS_W-1:0]  best_sum_next;
  logic [COL_W-1:0] best_col_next;
  logic [ROW_W-1:0] best_row_next;

  assign col_sum = CS_W'(older_cell) + CS_W'(newer_cell) + CS_W'(s1_value);
  assign win_sum = WS_W'(cs_prev2) + WS_W'(cs_prev1) + WS_W'(col_sum);
  assign take    = s1_window && (!found || (win_sum < best_sum));

  always_comb begin
    if (take) begin
      best_sum_next = win_sum;
      best_col_next = s1_col - COL_W'(WIN - 1);
      best_row_next = s1_row - ROW_W'(WIN - 1);
    end else begin
      best_sum_next = best_sum;
      best_col_next = best_col;
      best_row_next = best_row;
    end
  end

  // At the end of a grid the tracking state returns to its cleared form so
  // the next grid starts fresh on the very next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      cs_prev2 <= '0;
      cs_prev1 <= '0;
      found    <= 1'b0;
      best_sum <= '0;
      best_col <= '0;
      best_row <= '0;
    end else if (s1_valid) begin
      if (s1_last) begin
        cs_prev2 <= '0;
        cs_prev1 <= '0;
        found    <= 1'b0;
        best_sum <= '0;
        best_col <= '0;
        best_row <= '0;
      end else begin
        cs_prev2 <= cs_prev1;
        cs_prev1 <= col_sum;
        found    <= found || take;
        best_sum <= best_sum_next;
        best_col <= best_col_next;
        best_row <= best_row_next;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register. It is loaded with the grid's final best, including
  // the window closed by the last cell itself.
  // ---------------------------------------------------------------------
  logic [SUM_OUT_W-1:0] res_sum;
  logic [POS_OUT_W-1:0] res_col;
  logic [POS_OUT_W-1:0] res_row;
  logic                 res_load;

  assign res_load = s1_valid && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_sum <= SUM_OUT_W'(best_sum_next);
      res_col <= POS_OUT_W'(best_col_next);
      res_row <= POS_OUT_W'(best_row_next);
    end
  end

  assign results.valid            = res_valid;
  assign results.data.lowest_sum  = res_sum;
  assign results.data.best_column = res_col;
  assign results.data.best_row    = res_row;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // A new result never lands on an untaken one.
  `MWSL_ASSERT(a_no_result_overwrite, res_load |-> (!res_valid || results.ready))
  // The result of a grid becomes valid once its last cell has passed the s1 stage register and the output register.
  `MWSL_ASSERT(a_result_follows_last, (cell_xfer && last_now) |-> ##2 results.valid)
  // With no window seen yet in the grid, the tracked best sum and column are still cleared.
  `MWSL_ASSERT(a_best_clear_until_found, !found |-> (best_sum == '0 && best_col == '0))

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Testbench for min_window_sum_locator_core: streams grids of cells in raster order and checks
// every smallest 3x3 window sum and its position against a predictor held in this file.
// Depends on mwsl_pkg, mwsl_stream_if, min_window_sum_locator_core and the files that the core uses.

module testbench;
  import mwsl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  // The result shows up after the last cell has passed the stage register and the
  // output register; the settle wait lets the pipeline empty before the registers change.
  localparam int SETTLE_CYCLES = 4;
  // Without any stall the block accepts a cell every cycle; the longest
  // honest pause is a sender gap plus a receiver stall plus pipeline cycles.
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_COLUMNS = DEF_MAX_COLUMNS;
  localparam int MAX_ROWS = DEF_MAX_ROWS;
  localparam int COL_SUM_W = CELL_W + 2;
  localparam int RANDOM_ITEMS = 480;
  localparam int LONG_SPAN = 120;

  // Kinds of grid content. Tiny values make many equal sums, so the rule
  // that the first window in raster order wins is exercised often.
  typedef enum int {
    FILL_RANDOM,
    FILL_TINY,
    FILL_NEAR_MAX,
    FILL_FLAT,
    FILL_CHECKER
  } fill_kind_e;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  mwsl_stream_if #(.payload_t(cell_t)) cells ();
  mwsl_stream_if #(.payload_t(result_t)) results ();

  min_window_sum_locator_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cells   (cells),
    .results (results)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: the register settings as written, the two rows above
  // the current one, the last three vertical column sums, the position of
  // the next cell and the best window found so far in the current grid.
  logic [CFG_W-1:0] grid_cols_reg = GRID_DIM_RESET;
  logic [CFG_W-1:0] grid_rows_reg = GRID_DIM_RESET;
  logic [CELL_W-1:0] row_above_2 [MAX_COLUMNS] = '{default: '0};
  logic [CELL_W-1:0] row_above_1 [MAX_COLUMNS] = '{default: '0};
  logic [COL_SUM_W-1:0] column_sums [WIN] = '{default: '0};
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  logic [SUM_OUT_W-1:0] best_total = '0;
  logic [POS_OUT_W-1:0] best_col = '0;
  logic [POS_OUT_W-1:0] best_row = '0;
  bit window_seen = 1'b0;

  // Grid minima that the block still owes us, oldest first.
  result_t pending_minima[$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit cell_gaps_on = 1'b1;
  bit result_stalls_on = 1'b1;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Register values outside 3..ceiling are saturated when the block uses them.
  function automatic int unsigned clamped_dim(input logic [CFG_W-1:0] setting,
                                              input int unsigned ceiling);
    if (setting < WIN) return WIN;
    if (setting > ceiling) return ceiling;
    return setting;
  endfunction

  // Advances the predictor by one accepted cell. The window whose
  // bottom-right corner is this cell is the sum of the last three column
  // sums; only a strictly smaller sum replaces the best one, so ties keep
  // the earliest window. The last cell of a grid queues the grid minimum.
  function automatic void track_window_minimum(input logic [CELL_W-1:0] cell_in);
    int unsigned span_cols;
    int unsigned span_rows;
    logic [COL_SUM_W-1:0] column_total;
    logic [SUM_OUT_W-1:0] box_total;
    result_t grid_min;
    span_cols = clamped_dim(grid_cols_reg, MAX_COLUMNS);
    span_rows = clamped_dim(grid_rows_reg, MAX_ROWS);
    column_total = COL_SUM_W'(row_above_2[col_pos]) + COL_SUM_W'(row_above_1[col_pos])
                 + COL_SUM_W'(cell_in);
    column_sums[0] = column_sums[1];
    column_sums[1] = column_sums[2];
    column_sums[2] = column_total;
    if (row_pos >= WIN - 1 && col_pos >= WIN - 1) begin
      box_total = SUM_OUT_W'(column_sums[0]) + SUM_OUT_W'(column_sums[1])
                + SUM_OUT_W'(column_sums[2]);
      if (!window_seen || box_total < best_total) begin
        best_total = box_total;
        best_col = POS_OUT_W'(col_pos - (WIN - 1));
        best_row = POS_OUT_W'(row_pos - (WIN - 1));
        window_seen = 1'b1;
      end
    end
    row_above_2[col_pos] = row_above_1[col_pos];
    row_above_1[col_pos] = cell_in;
    if (col_pos + 1 >= span_cols) begin
      col_pos = 0;
      if (row_pos + 1 >= span_rows) begin
        grid_min.lowest_sum = best_total;
        grid_min.best_column = best_col;
        grid_min.best_row = best_row;
        pending_minima.push_back(grid_min);
        column_sums = '{default: '0};
        row_pos = 0;
        best_total = '0;
        best_col = '0;
        best_row = '0;
        window_seen = 1'b0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endfunction

  // Sends one cell after a random gap and updates the predictor once the
  // transfer has happened. Valid stays high into the next call when there is
  // no gap, so back-to-back cells go out on consecutive cycles.
  task automatic send_cell(input logic [CELL_W-1:0] value);
    int unsigned gap;
    gap = cell_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      cells.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cells.valid <= 1'b1;
    cells.data <= '{cell_value: value};
    do @(posedge clk); while (!cells.ready);
    track_window_minimum(value);
  endtask

  task automatic stream_grid_cells(input int unsigned count, input fill_kind_e kind,
                                   input logic [CELL_W-1:0] level);
    logic [CELL_W-1:0] value;
    for (int unsigned i = 0; i < count; i++) begin
      case (kind)
        FILL_TINY:     value = CELL_W'($urandom_range(0, 3));
        FILL_NEAR_MAX: value = CELL_W'(16'hFFFF - $urandom_range(0, 3));
        FILL_FLAT:     value = level;
        FILL_CHECKER:  value = i[0] ? 16'hAAAA : 16'h5555;
        default:       value = CELL_W'($urandom_range(0, 16'hFFFF));
      endcase
      send_cell(value);
    end
  endtask

  // Drops valid, waits until every predicted minimum has come back, and then
  // lets the pipeline run empty so a register write cannot land on a cell
  // that the block is still working on.
  task automatic wait_until_idle();
    cells.valid <= 1'b0;
    do @(posedge clk); while (pending_minima.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one grid register (random upper data bits, which the block must
  // ignore), then reads it back in a second transfer and checks the value.
  task automatic write_grid_reg(input reg_idx_t which, input logic [CFG_W-1:0] value);
    logic [APB_DATA_W-1:0] word;
    word = $urandom();
    word[CFG_W-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (which == REG_GRID_WIDTH) begin
      grid_cols_reg = value;
    end else begin
      grid_rows_reg = value;
    end
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CFG_W-1:0] !== value) begin
      report_mismatch($sformatf("register %s read %0d, written %0d", which.name(),
                                prdata[CFG_W-1:0], value));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid_shape(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    write_grid_reg(REG_GRID_WIDTH, cols);
    write_grid_reg(REG_GRID_HEIGHT, rows);
  endtask

  // Both registers go through their extremes and out-of-range values, and
  // each value must read back unchanged. The run continues from 3x3.
  task automatic test_register_access();
    logic [CFG_W-1:0] probes [7];
    probes = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd1024, 11'd2047, 11'd0};
    probes[6] = CFG_W'($urandom_range(0, 2047));
    foreach (probes[i]) begin
      set_grid_shape(probes[i], ~probes[i]);
    end
    set_grid_shape(GRID_DIM_RESET, GRID_DIM_RESET);
  endtask

  // A 4x3 grid of full-scale cells: the largest possible sum, and two equal
  // windows, of which the left one must be reported.
  task automatic test_saturated_tie();
    set_grid_shape(11'd4, 11'd3);
    stream_grid_cells(12, FILL_FLAT, 16'hFFFF);
    wait_until_idle();
  endtask

  // Width and height below the minimum both behave as 3. The alternating
  // pattern drives every bit of a cell both ways.
  task automatic test_clamped_dims();
    set_grid_shape(11'd0, 11'd2);
    stream_grid_cells(9, FILL_CHECKER, '0);
    wait_until_idle();
  endtask

  // A register change in the middle of a grid takes effect on the next cell.
  // The grid starts as 5x4; in the third row both registers drop to 3, so the
  // row and the grid end early. The width shrinks rather than grows, so every row entry
  // read afterwards was written in this grid.
  task automatic test_mid_grid_change();
    set_grid_shape(11'd5, 11'd4);
    stream_grid_cells(11, FILL_TINY, '0);
    wait_until_idle();
    set_grid_shape(11'd3, 11'd3);
    stream_grid_cells(2, FILL_TINY, '0);
    wait_until_idle();
  endtask

  // Small grids of random shape and content, with the idling of both sides
  // switched on or off per grid. Now and then a register value below the
  // minimum is written so that clamping is seen in random traffic too.
  task automatic test_random_grids(input int unsigned item_budget);
    int unsigned sent;
    int unsigned cols;
    int unsigned rows;
    fill_kind_e kind;
    sent = 0;
    while (sent < item_budget) begin
      cols = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
      kind = fill_kind_e'($urandom_range(0, 4));
      set_grid_shape(CFG_W'(cols), CFG_W'(rows));
      cell_gaps_on = $urandom_range(0, 3) != 0;
      result_stalls_on = $urandom_range(0, 3) != 0;
      cols = clamped_dim(CFG_W'(cols), MAX_COLUMNS);
      rows = clamped_dim(CFG_W'(rows), MAX_ROWS);
      stream_grid_cells(cols * rows, kind, CELL_W'($urandom()));
      sent += cols * rows;
      wait_until_idle();
    end
    cell_gaps_on = 1'b1;
    result_stalls_on = 1'b1;
  endtask

  // A long, flat grid and a tall, narrow one, each three cells across the
  // short side, so that positions well past the small random shapes are
  // reported and the long grid uses row store addresses up to 119.
  task automatic test_large_grids();
    set_grid_shape(CFG_W'(LONG_SPAN), 11'd3);
    stream_grid_cells(LONG_SPAN * WIN, FILL_RANDOM, '0);
    wait_until_idle();
    set_grid_shape(11'd3, CFG_W'(LONG_SPAN));
    stream_grid_cells(LONG_SPAN * WIN, FILL_NEAR_MAX, '0);
    wait_until_idle();
  endtask

  // Result side: for every result, a random stall with ready low, then ready
  // stays high until a transfer takes place.
  initial begin : result_acceptor
    int unsigned stall;
    results.ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = result_stalls_on ? $urandom_range(0, 6) : 0;
      if (stall != 0) begin
        results.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (!(results.valid && results.ready));
    end
  end

  // Every result transfer is compared field by field with the oldest
  // predicted grid minimum. Values are sampled at the edge, before any
  // update scheduled for that edge takes place.
  always @(posedge clk) begin : result_checker
    result_t want;
    if (!rst && results.valid && results.ready) begin
      if (pending_minima.size() == 0) begin
        report_mismatch($sformatf("result sum %0d col %0d row %0d with no grid pending",
                                  results.data.lowest_sum, results.data.best_column,
                                  results.data.best_row));
      end else begin
        want = pending_minima.pop_front();
        if (results.data.lowest_sum !== want.lowest_sum) begin
          report_mismatch($sformatf("lowest_sum %0d, expected %0d",
                                    results.data.lowest_sum, want.lowest_sum));
        end
        if (results.data.best_column !== want.best_column) begin
          report_mismatch($sformatf("best_column %0d, expected %0d",
                                    results.data.best_column, want.best_column));
        end
        if (results.data.best_row !== want.best_row) begin
          report_mismatch($sformatf("best_row %0d, expected %0d",
                                    results.data.best_row, want.best_row));
        end
      end
    end
  end

  // Watchdog: any cell, result or register transfer counts as progress.
  // A long stretch without one means the block has hung.
  always @(posedge clk) begin
    if (rst || (cells.valid && cells.ready) || (results.valid && results.ready)
        || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $realtime, quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : run_tests
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cells.valid = 1'b0;
    cells.data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_access();
    test_saturated_tie();
    test_clamped_dims();
    test_mid_grid_change();
    test_random_grids(RANDOM_ITEMS);
    test_large_grids();

    // All cells are in; wait_until_idle has already drained the outstanding
    // minima and given the block time to show any stray result.
    wait_until_idle();
    if (mismatch_count == 0 && pending_minima.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
